[hdl/smm_pkg.sv]
`timescale 1ns / 1ps

package smm_pkg;

	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 32;
	localparam int SUM_W     = 35;
	localparam int OUT_IDX_W = 3;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int ACT_W     = 2;

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT    = 2'd0,
		REG_COLUMN_COUNT = 2'd1,
		REG_INNER_COUNT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ISSUE,
		SEQ_WAIT
	} seq_state_t;

	// One read pair issued to the stores and the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} issue_t;

	// Result element handed from the sequencer to the output register
	typedef struct packed {
		logic                 load;
		logic [OUT_IDX_W-1:0] row;
		logic [OUT_IDX_W-1:0] column;
		logic                 last_elem;
	} emit_t;

endpackage

[hdl/smm_store.sv]
`timescale 1ns / 1ps

module smm_store import smm_pkg::*; #(
	parameter int MAX_DIM = 8,
	parameter int ADDR_W  = 6
) (
	input  logic                     clk,
	input  logic                     we_a,
	input  logic                     we_b,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic signed [ELEM_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]        rd_addr_a,
	input  logic [ADDR_W-1:0]        rd_addr_b,
	output logic signed [ELEM_W-1:0] rd_a_q,
	output logic signed [ELEM_W-1:0] rd_b_q
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic signed [ELEM_W-1:0] left_mem  [DEPTH];
	logic signed [ELEM_W-1:0] right_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we_a) begin
			left_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= left_mem[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			right_mem[wr_addr] <= wr_data;
		end
		rd_b_q <= right_mem[rd_addr_b];
	end

endmodule

[hdl/smm_mac.sv]
`timescale 1ns / 1ps

module smm_mac import smm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  issue_t                   issue,
	input  logic signed [ELEM_W-1:0] rd_a,
	input  logic signed [ELEM_W-1:0] rd_b,
	input  logic                     take,
	output logic signed [SUM_W-1:0]  acc_q,
	output logic                     done_q
);

	issue_t                   ctrl_s1;
	issue_t                   ctrl_s2;
	logic signed [PROD_W-1:0] product_s2;

	// Align control with the registered store read, then with the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q  <= 1'b0;
		end else begin
			ctrl_s1 <= issue;
			ctrl_s2 <= ctrl_s1;
			if (ctrl_s2.valid && ctrl_s2.last) begin
				done_q <= 1'b1;
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		product_s2 <= rd_a * rd_b;
		if (ctrl_s2.valid) begin
			if (ctrl_s2.first) begin
				acc_q <= SUM_W'(product_s2);
			end else begin
				acc_q <= acc_q + SUM_W'(product_s2);
			end
		end
	end

endmodule

[hdl/smm_seq.sv]
`timescale 1ns / 1ps

module smm_seq import smm_pkg::*; #(
	parameter int IDX_W  = 3,
	parameter int DIM_W  = 4,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIM_W-1:0]  m_dim,
	input  logic [DIM_W-1:0]  n_dim,
	input  logic [DIM_W-1:0]  k_dim,
	input  logic              mac_done,
	input  logic              out_free,
	output logic              busy,
	output issue_t            issue,
	output logic [ADDR_W-1:0] rd_addr_a,
	output logic [ADDR_W-1:0] rd_addr_b,
	output emit_t             emit
);

	seq_state_t        state_q, state_d;
	logic [IDX_W-1:0]  i_q, i_d;
	logic [IDX_W-1:0]  j_q, j_d;
	logic [IDX_W-1:0]  t_q, t_d;
	logic [ADDR_W-1:0] a_base_q, a_base_d;
	logic [ADDR_W-1:0] b_addr_q, b_addr_d;
	logic              t_last;
	logic              j_last;
	logic              i_last;

	assign t_last = (DIM_W'(t_q) + DIM_W'(1)) == k_dim;
	assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == n_dim;
	assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == m_dim;

	assign rd_addr_a = a_base_q + ADDR_W'(t_q);
	assign rd_addr_b = b_addr_q;
	assign busy      = (state_q != SEQ_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SEQ_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_base_q <= '0;
			b_addr_q <= '0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			t_q      <= t_d;
			a_base_q <= a_base_d;
			b_addr_q <= b_addr_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		t_d      = t_q;
		a_base_d = a_base_q;
		b_addr_d = b_addr_q;
		issue    = '0;
		emit.load      = 1'b0;
		emit.row       = OUT_IDX_W'(i_q);
		emit.column    = OUT_IDX_W'(j_q);
		emit.last_elem = i_last && j_last;

		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d  = SEQ_ISSUE;
					i_d      = '0;
					j_d      = '0;
					t_d      = '0;
					a_base_d = '0;
					b_addr_d = '0;
				end
			end
			SEQ_ISSUE: begin
				issue.valid = 1'b1;
				issue.first = (t_q == '0);
				issue.last  = t_last;
				if (t_last) begin
					state_d = SEQ_WAIT;
				end else begin
					t_d      = t_q + IDX_W'(1);
					b_addr_d = b_addr_q + ADDR_W'(n_dim);
				end
			end
			SEQ_WAIT: begin
				// hold until the sum is complete and the output register can take it
				if (mac_done && out_free) begin
					emit.load = 1'b1;
					t_d       = '0;
					if (j_last) begin
						j_d      = '0;
						b_addr_d = '0;
						if (i_last) begin
							state_d = SEQ_IDLE;
						end else begin
							state_d  = SEQ_ISSUE;
							i_d      = i_q + IDX_W'(1);
							a_base_d = a_base_q + ADDR_W'(k_dim);
						end
					end else begin
						state_d  = SEQ_ISSUE;
						j_d      = j_q + IDX_W'(1);
						b_addr_d = ADDR_W'(j_q) + ADDR_W'(1);
					end
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

[hdl/small_matrix_multiply.sv]
// Load beats (A or B element) are accepted back to back while no compute is running.
// A compute beat produces the M*N result elements one at a time: each element's K
// products pass through the single store read port pair and shared multiplier, and
// the sum drains through the read, multiply and accumulate registers before the next starts.
// Reset (arst_n, asynchronous, active low) sets all dimensions to 8 and both fill
// counts to zero; store contents are undefined until loaded.
`timescale 1ns / 1ps

module small_matrix_multiply import smm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ACT_W-1:0]            action,
	input  logic signed [ELEM_W-1:0]    element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [OUT_IDX_W-1:0]        out_row,
	output logic [OUT_IDX_W-1:0]        out_column,
	output logic signed [SUM_W-1:0]     product_sum,
	output logic                        final_flag,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (FILL_W > 2 * DIM_W) ? FILL_W : 2 * DIM_W;

	logic [CFG_W-1:0]         row_count_q;
	logic [CFG_W-1:0]         column_count_q;
	logic [CFG_W-1:0]         inner_count_q;
	logic [DIM_W-1:0]         m_dim;
	logic [DIM_W-1:0]         n_dim;
	logic [DIM_W-1:0]         k_dim;
	logic [2*DIM_W-1:0]       mk_size;
	logic [2*DIM_W-1:0]       kn_size;
	logic [FILL_W-1:0]        left_fill_q;
	logic [FILL_W-1:0]        right_fill_q;
	logic                     in_beat;
	logic                     we_a;
	logic                     we_b;
	logic                     start;
	logic [ADDR_W-1:0]        wr_addr;
	logic [ADDR_W-1:0]        rd_addr_a;
	logic [ADDR_W-1:0]        rd_addr_b;
	logic signed [ELEM_W-1:0] rd_a;
	logic signed [ELEM_W-1:0] rd_b;
	logic signed [SUM_W-1:0]  acc;
	logic                     mac_done;
	logic                     busy;
	logic                     out_free;
	issue_t                   issue;
	emit_t                    emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= DIM_RESET;
			column_count_q <= DIM_RESET;
			inner_count_q  <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				REG_INNER_COUNT:  inner_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp register values into 1..MAX_DIM
	always_comb begin
		m_dim = (row_count_q == '0) ? DIM_W'(1) :
			(row_count_q > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(row_count_q);
		n_dim = (column_count_q == '0) ? DIM_W'(1) :
			(column_count_q > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(column_count_q);
		k_dim = (inner_count_q == '0) ? DIM_W'(1) :
			(inner_count_q > CFG_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(inner_count_q);
	end

	assign mk_size = (2 * DIM_W)'(m_dim) * (2 * DIM_W)'(k_dim);
	assign kn_size = (2 * DIM_W)'(k_dim) * (2 * DIM_W)'(n_dim);

	assign in_stall = busy;
	assign in_beat  = in_valid && !in_stall;
	assign start    = in_beat && (action == ACT_COMPUTE);
	// drop loads beyond the matrix size
	assign we_a = in_beat && (action == ACT_LOAD_A) &&
		(CMP_W'(left_fill_q) < CMP_W'(mk_size));
	assign we_b = in_beat && (action == ACT_LOAD_B) &&
		(CMP_W'(right_fill_q) < CMP_W'(kn_size));
	assign wr_addr = we_a ? left_fill_q[ADDR_W-1:0] : right_fill_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_fill_q  <= '0;
			right_fill_q <= '0;
		end else if (start) begin
			left_fill_q  <= '0;
			right_fill_q <= '0;
		end else begin
			if (we_a) begin
				left_fill_q <= left_fill_q + FILL_W'(1);
			end
			if (we_b) begin
				right_fill_q <= right_fill_q + FILL_W'(1);
			end
		end
	end

	smm_store #(
		.MAX_DIM (MAX_DIM),
		.ADDR_W  (ADDR_W)
	) u_store (
		.clk       (clk),
		.we_a      (we_a),
		.we_b      (we_b),
		.wr_addr   (wr_addr),
		.wr_data   (element),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_a_q    (rd_a),
		.rd_b_q    (rd_b)
	);

	smm_seq #(
		.IDX_W  (IDX_W),
		.DIM_W  (DIM_W),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.m_dim     (m_dim),
		.n_dim     (n_dim),
		.k_dim     (k_dim),
		.mac_done  (mac_done),
		.out_free  (out_free),
		.busy      (busy),
		.issue     (issue),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.emit      (emit)
	);

	smm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.take   (emit.load),
		.acc_q  (acc),
		.done_q (mac_done)
	);

	// Output register: a waiting result holds the sequencer, and so the input side, while a compute runs
	logic                    out_valid_q;
	logic [OUT_IDX_W-1:0]    out_row_q;
	logic [OUT_IDX_W-1:0]    out_column_q;
	logic signed [SUM_W-1:0] product_sum_q;
	logic                    final_flag_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_row_q     <= emit.row;
			out_column_q  <= emit.column;
			product_sum_q <= acc;
			final_flag_q  <= emit.last_elem;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_column  = out_column_q;
	assign product_sum = product_sum_q;
	assign final_flag  = final_flag_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> out_free)
		else $error("result loaded over an untaken beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_row) &&
			$stable(out_column) && $stable(product_sum) && $stable(final_flag)))
		else $error("stalled result beat changed");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CMP_W'(left_fill_q) <= CMP_W'(DEPTH)) && (CMP_W'(right_fill_q) <= CMP_W'(DEPTH)))
		else $error("fill count beyond store depth");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> mac_done)
		else $error("result loaded before the sum was complete");

endmodule
